// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/tlbpt_pkg.sv
// ---------------------------------------------------------------------------
// TLB page translator package
// Fixed field widths and the control word of the TLB line chain.
// ---------------------------------------------------------------------------
package tlbpt_pkg;

   // address space geometry; every field width follows from these
   localparam int PAGE_COUNT   = 1024;
   localparam int FRAME_COUNT  = 256;
   localparam int OFFSET_WIDTH = 10;

   localparam int VA_WIDTH  = $clog2(PAGE_COUNT) + OFFSET_WIDTH;
   localparam int PA_WIDTH  = $clog2(FRAME_COUNT) + OFFSET_WIDTH;
   localparam int EVP_WIDTH = $clog2(PAGE_COUNT);

   typedef enum logic {
      MODE_FIFO = 1'b0,
      MODE_LRU  = 1'b1
   } repl_mode_type;

   // shift: push a new line in at the head; rewrite: the line holding the
   // fill frame takes the fill page
   typedef struct packed {
      logic shift;
      logic rewrite;
   } tlb_ctl_type;

endpackage

// File: rtl/tlbpt_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Carries one virtual address per word.
// ---------------------------------------------------------------------------
interface tlbpt_req_if;
   import tlbpt_pkg::*;

   logic                valid;
   logic                ready;
   logic [VA_WIDTH-1:0] virtual_address;

   modport source (output valid, output virtual_address, input ready);
   modport sink   (input valid, input virtual_address, output ready);
endinterface

// File: rtl/tlbpt_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Carries the translation and fault flags of one address per word.
// ---------------------------------------------------------------------------
interface tlbpt_rsp_if;
   import tlbpt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [PA_WIDTH-1:0]  phys_addr;
   logic                 tlb_hit;
   logic                 page_fault;
   logic                 evicted_valid;
   logic [EVP_WIDTH-1:0] evicted_page;

   modport source (output valid, output phys_addr, output tlb_hit,
                   output page_fault, output evicted_valid, output evicted_page,
                   input ready);
   modport sink   (input valid, input phys_addr, input tlb_hit,
                   input page_fault, input evicted_valid, input evicted_page,
                   output ready);
endinterface

// File: rtl/tlb_page_translator_fifo_lru_unit.sv
// ---------------------------------------------------------------------------
// TLB page translator with FIFO or LRU frame replacement
// A request passes through the look, rank and commit states, which serve the
// page-map read, the owner read and the rank update, and then the response
// register; a busy slot holds it in the hold state. No new address is taken until
// the last is through. After reset a clearing pass marks every page unmapped;
// no request is taken until it ends.
`include "assert_macros.svh"

module tlb_page_translator_fifo_lru_unit #(
   parameter int TLB_LINES = 16
) (
   input  logic      clock,
   input  logic      reset,
   tlbpt_req_if.sink   req,
   tlbpt_rsp_if.source rsp,
   input  logic      csr_write_enable,
   input  logic      csr_write_data
);
   import tlbpt_pkg::*;

   // page and frame counts are powers of two; index widths follow from them
   localparam int PW = $clog2(PAGE_COUNT);
   localparam int FW = $clog2(FRAME_COUNT);
   localparam int CW = $clog2(FRAME_COUNT + 1);
   localparam int OW = OFFSET_WIDTH;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOOK, ST_RANK, ST_COMMIT, ST_HOLD
   } state_type;

   state_type     state_ff, state_in;
   logic [PW-1:0] clr_ff, clr_in;
   repl_mode_type mode_ff, mode_in;
   logic [PW-1:0] page_ff, page_in;
   logic [OW-1:0] offset_ff, offset_in;
   logic [FW-1:0] frame_ff, frame_in;
   logic          hit_ff, hit_in;
   logic          fault_ff, fault_in;
   logic          evict_ff, evict_in;
   logic [FW-1:0] old_rank_ff, old_rank_in;
   logic [PW-1:0] ev_page_ff, ev_page_in;
   logic [CW-1:0] count_ff, count_in;
   logic [FW-1:0] fifo_ff, fifo_in;
   logic [FW-1:0] lru_ff, lru_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PA_WIDTH-1:0]  rsp_pa_ff;
   logic                 rsp_hit_ff, rsp_fault_ff, rsp_ev_valid_ff;
   logic [EVP_WIDTH-1:0] rsp_ev_page_ff;
   logic                 rsp_free, load_rsp;

   // page map: mapped flag over frame number
   logic [FW:0]   map_mem [PAGE_COUNT];
   logic [FW:0]   map_rd_ff;
   logic          map_we;
   logic [PW-1:0] map_waddr;
   logic [FW:0]   map_wdata;

   logic [PW-1:0] owner_mem [FRAME_COUNT];
   logic [PW-1:0] owner_rd_ff;
   logic          owner_we;

   logic [PW-1:0] req_page;

   tlb_ctl_type   tlb_ctl;
   logic          line_valid [TLB_LINES];
   logic [PW-1:0] line_page  [TLB_LINES];
   logic [FW-1:0] line_frame [TLB_LINES];
   logic [TLB_LINES-1:0] line_hit, line_fmatch;
   logic [FW-1:0] tlb_frame;

   logic                   rank_upd;
   logic [FW-1:0]          sel_rank  [FRAME_COUNT];
   logic [FRAME_COUNT-1:0] lru_flag;
   logic [FW-1:0]          rank_of_frame;

   assign req_page  = req.virtual_address[OW +: PW];
   assign req.ready = (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   // TLB: a chain of lines, newest at the head, oldest dropped off the tail
   for (genvar i = 0; i < TLB_LINES; i++) begin : g_line
      logic          pv;
      logic [PW-1:0] pp;
      logic [FW-1:0] pf;
      if (i == 0) begin : g_head
         assign pv = 1'b1;
         assign pp = page_ff;
         assign pf = frame_ff;
      end else begin : g_body
         assign pv = line_valid[i-1];
         assign pp = line_page[i-1];
         assign pf = line_frame[i-1];
      end
      tlbpt_tlb_line #(.PW(PW), .FW(FW)) u_line (
         .clock       (clock),
         .reset       (reset),
         .ctl         (tlb_ctl),
         .prev_valid  (pv),
         .prev_page   (pp),
         .prev_frame  (pf),
         .look_page   (page_ff),
         .fill_page   (page_ff),
         .fill_frame  (frame_ff),
         .line_valid  (line_valid[i]),
         .line_page   (line_page[i]),
         .line_frame  (line_frame[i]),
         .hit         (line_hit[i]),
         .frame_match (line_fmatch[i])
      );
   end

   // pages are unique in the TLB, so at most one line hits
   always_comb begin
      tlb_frame = '0;
      for (int i = 0; i < TLB_LINES; i++) begin
         if (line_hit[i]) tlb_frame = tlb_frame | line_frame[i];
      end
   end

   // one rank cell per frame
   for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_rank
      tlbpt_rank_cell #(.FW(FW), .CW(CW), .INDEX(g)) u_rank (
         .clock     (clock),
         .update    (rank_upd),
         .sel_frame (frame_ff),
         .old_rank  (old_rank_ff),
         .count_new (count_in),
         .lru_rank  (FW'(FRAME_COUNT - 1)),
         .sel_rank  (sel_rank[g]),
         .lru_flag  (lru_flag[g])
      );
   end

   always_comb begin
      rank_of_frame = '0;
      lru_in        = '0;
      for (int g = 0; g < FRAME_COUNT; g++) begin
         rank_of_frame = rank_of_frame | sel_rank[g];
         if (lru_flag[g]) lru_in = lru_in | FW'(g);
      end
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      mode_in     = csr_write_enable ? repl_mode_type'(csr_write_data) : mode_ff;
      page_in     = page_ff;
      offset_in   = offset_ff;
      frame_in    = frame_ff;
      hit_in      = hit_ff;
      fault_in    = fault_ff;
      evict_in    = evict_ff;
      old_rank_in = old_rank_ff;
      ev_page_in  = ev_page_ff;
      count_in    = count_ff;
      fifo_in     = fifo_ff;
      map_we      = 1'b0;
      map_waddr   = page_ff;
      map_wdata   = '0;
      owner_we    = 1'b0;
      tlb_ctl     = '0;
      rank_upd    = 1'b0;
      load_rsp    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // mark every page unmapped
            map_we    = 1'b1;
            map_waddr = clr_ff;
            if (clr_ff == PW'(PAGE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + PW'(1);
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               page_in   = req_page;
               offset_in = req.virtual_address[OW-1:0];
               state_in  = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // TLB first, then the page map, else take a frame
            hit_in   = |line_hit;
            fault_in = 1'b0;
            evict_in = 1'b0;
            if (|line_hit) begin
               frame_in = tlb_frame;
            end else if (map_rd_ff[FW]) begin
               frame_in = map_rd_ff[FW-1:0];
            end else begin
               fault_in = 1'b1;
               if (count_ff < CW'(FRAME_COUNT)) begin
                  frame_in = count_ff[FW-1:0];
               end else begin
                  evict_in = 1'b1;
                  frame_in = (mode_ff == MODE_LRU) ? lru_ff : fifo_ff;
               end
            end
            state_in = ST_RANK;
         end
         ST_RANK: begin
            // a fresh frame ranks behind every frame in use
            old_rank_in = (fault_ff && !evict_ff) ? count_ff[FW-1:0] : rank_of_frame;
            if (evict_ff) begin
               map_we     = 1'b1;
               map_waddr  = owner_rd_ff;
               ev_page_in = owner_rd_ff;
            end else begin
               ev_page_in = '0;
            end
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (fault_ff) begin
               map_we    = 1'b1;
               map_waddr = page_ff;
               map_wdata = {1'b1, frame_ff};
               owner_we  = 1'b1;
               count_in  = count_ff + CW'(!evict_ff);
               fifo_in   = fifo_ff + FW'(1);
            end
            if (!hit_ff) begin
               tlb_ctl.shift   = !(|line_fmatch);
               tlb_ctl.rewrite = |line_fmatch;
            end
            rank_upd = 1'b1;
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // hold the finished word until the response slot frees
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         mode_ff      <= MODE_FIFO;
         count_ff     <= '0;
         fifo_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         fifo_ff      <= fifo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      offset_ff   <= offset_in;
      frame_ff    <= frame_in;
      hit_ff      <= hit_in;
      fault_ff    <= fault_in;
      evict_ff    <= evict_in;
      old_rank_ff <= old_rank_in;
      ev_page_ff  <= ev_page_in;
      lru_ff      <= lru_in;
      if (load_rsp) begin
         rsp_pa_ff       <= PA_WIDTH'({frame_ff, offset_ff});
         rsp_hit_ff      <= hit_ff;
         rsp_fault_ff    <= fault_ff;
         rsp_ev_valid_ff <= evict_ff;
         rsp_ev_page_ff  <= EVP_WIDTH'(ev_page_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem[map_waddr] <= map_wdata;
      map_rd_ff <= map_mem[req_page];
   end

   always_ff @(posedge clock) begin
      if (owner_we) owner_mem[frame_ff] <= page_ff;
      owner_rd_ff <= owner_mem[frame_in];
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.phys_addr     = rsp_pa_ff;
   assign rsp.tlb_hit       = rsp_hit_ff;
   assign rsp.page_fault    = rsp_fault_ff;
   assign rsp.evicted_valid = rsp_ev_valid_ff;
   assign rsp.evicted_page  = rsp_ev_page_ff;

   `ASSERT_NEXT(a_accept_looks, clock, reset, req.valid && req.ready, state_ff == ST_LOOK)
   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(FRAME_COUNT))
   `ASSERT_IMPL(a_evict_is_fault, clock, reset, rsp.valid && rsp.evicted_valid, rsp.page_fault)
   `ASSERT_IMPL(a_tlb_single_hit, clock, reset, state_ff == ST_LOOK, $onehot0(line_hit))
   `ASSERT_IMPL(a_lru_unique, clock, reset, state_ff == ST_LOOK && count_ff == CW'(FRAME_COUNT), $onehot(lru_flag))
endmodule

// File: rtl/tlbpt_tlb_line.sv
// ---------------------------------------------------------------------------
// TLB line cell
// One translation entry; takes its left neighbour's entry on a shift.
// ---------------------------------------------------------------------------
module tlbpt_tlb_line #(
   parameter int PW = 10,
   parameter int FW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tlbpt_pkg::tlb_ctl_type ctl,
   input  logic                  prev_valid,
   input  logic [PW-1:0]         prev_page,
   input  logic [FW-1:0]         prev_frame,
   input  logic [PW-1:0]         look_page,
   input  logic [PW-1:0]         fill_page,
   input  logic [FW-1:0]         fill_frame,
   output logic                  line_valid,
   output logic [PW-1:0]         line_page,
   output logic [FW-1:0]         line_frame,
   output logic                  hit,
   output logic                  frame_match
);
   import tlbpt_pkg::*;

   logic          valid_ff;
   logic [PW-1:0] page_ff;
   logic [FW-1:0] frame_ff;

   assign hit         = valid_ff && (page_ff == look_page);
   assign frame_match = valid_ff && (frame_ff == fill_frame);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         page_ff  <= prev_page;
         frame_ff <= prev_frame;
      end else if (ctl.rewrite && frame_match) begin
         page_ff <= fill_page;
      end
   end

   assign line_valid = valid_ff;
   assign line_page  = page_ff;
   assign line_frame = frame_ff;
endmodule

// File: rtl/tlbpt_rank_cell.sv
// ---------------------------------------------------------------------------
// Recency rank cell
// Holds the recency rank of one frame; 0 is the most recently used.
// ---------------------------------------------------------------------------
module tlbpt_rank_cell #(
   parameter int FW    = 8,
   parameter int CW    = 9,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          update,
   input  logic [FW-1:0] sel_frame,
   input  logic [FW-1:0] old_rank,
   input  logic [CW-1:0] count_new,
   input  logic [FW-1:0] lru_rank,
   output logic [FW-1:0] sel_rank,
   output logic          lru_flag
);
   localparam logic [FW-1:0] MY_FRAME = FW'(INDEX);
   localparam logic [CW-1:0] MY_COUNT = CW'(INDEX);

   logic [FW-1:0] rank_ff;
   logic          sel;
   logic          in_use;

   assign sel      = (sel_frame == MY_FRAME);
   assign in_use   = (MY_COUNT < count_new);
   assign sel_rank = sel ? rank_ff : '0;
   assign lru_flag = (rank_ff == lru_rank);

   // selected frame goes to the front; younger frames age by one
   always_ff @(posedge clock) begin
      if (update) begin
         if (sel) begin
            rank_ff <= '0;
         end else if (in_use && (rank_ff < old_rank)) begin
            rank_ff <= rank_ff + FW'(1);
         end
      end
   end
endmodule
